// ===== design/vcf_pkg.sv =====
// types, codes and helpers for the virtual coupling force block
// no dependencies
`default_nettype none

package vcf_pkg;

  typedef enum logic {
    ACT_CONTACT = 1'b0,
    ACT_FINISH  = 1'b1
  } action_t;

  typedef enum logic {
    REG_STIFFNESS = 1'b0,
    REG_DAMPING   = 1'b1
  } cfg_reg_t;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumAxes  = 3;

  // largest damping product that still fits after the times-ten step
  localparam logic [63:0] DampLimit = 64'h1999_9999_9999_9999;

  localparam logic signed [47:0] Force48Max = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] Force48Min = 48'sh8000_0000_0000;

  localparam logic signed [40:0] Sat32Hi = 41'sd2147483647;
  localparam logic signed [40:0] Sat32Lo = -41'sd2147483648;

  typedef struct packed {
    action_t            action;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [23:0]        depth;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic               force_valid;
    logic signed [31:0] visual_x;
    logic signed [31:0] visual_y;
    logic signed [31:0] visual_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > Sat32Hi) begin
      r = 32'sh7fff_ffff;
    end else if (v < Sat32Lo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/virtual_coupling_force.sv =====
// Virtual coupling spring-damper: one contact item or one finish item per
// cycle while in_stall is low. Contact items fold into the 3-axis sum in the
// cycle after acceptance; a finish item yields its result through an
// input register, four arithmetic stages (velocity difference, multipliers,
// times-ten scaling, signed combine) and an output register with rounding
// and saturation. Every stage advances on its own, so a result waiting on
// out_stall does not stop new items from entering until the pipeline is full.
// depends on vcf_pkg
`default_nettype none

module virtual_coupling_force
  import vcf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_item,
  input  wire logic                cfg_wr_en,
  input  wire cfg_reg_t            cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // configuration
  logic [31:0] stiff_r, damp_r;

  // accumulator state
  logic signed [31:0] sum_r [NumAxes];
  logic signed [31:0] prev_r [NumAxes];
  logic               any_r;
  logic               first_r;

  // input register
  logic     s0_v_r;
  in_item_t s0_r;

  // stage 1: sum, position and velocity magnitude
  logic               s1_v_r, s1_fv_r;
  logic signed [31:0] s1_off_r  [NumAxes];
  logic signed [31:0] s1_pos_r  [NumAxes];
  logic [32:0]        s1_dmag_r [NumAxes];
  logic               s1_dn_r   [NumAxes];

  // stage 2: products
  logic               s2_v_r, s2_fv_r;
  logic signed [31:0] s2_off_r [NumAxes];
  logic signed [31:0] s2_vis_r [NumAxes];
  logic [63:0]        s2_sm_r  [NumAxes];
  logic               s2_sn_r  [NumAxes];
  logic [64:0]        s2_dp_r  [NumAxes];
  logic               s2_dn_r  [NumAxes];

  // stage 3: scaled damping term
  logic               s3_v_r, s3_fv_r;
  logic signed [31:0] s3_off_r [NumAxes];
  logic signed [31:0] s3_vis_r [NumAxes];
  logic [63:0]        s3_sm_r  [NumAxes];
  logic               s3_sn_r  [NumAxes];
  logic [63:0]        s3_dm_r  [NumAxes];
  logic               s3_dn_r  [NumAxes];

  // stage 4: signed magnitude of the total
  logic               s4_v_r, s4_fv_r;
  logic signed [31:0] s4_off_r [NumAxes];
  logic signed [31:0] s4_vis_r [NumAxes];
  logic [63:0]        s4_mag_r [NumAxes];
  logic               s4_neg_r [NumAxes];

  // output register
  logic      out_v_r;
  out_item_t out_r;

  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic s0_contact, fire0;

  assign rdy_out    = !out_v_r || !out_stall;
  assign rdy4       = !s4_v_r || rdy_out;
  assign rdy3       = !s3_v_r || rdy4;
  assign rdy2       = !s2_v_r || rdy3;
  assign rdy1       = !s1_v_r || rdy2;
  assign s0_contact = (s0_r.action == ACT_CONTACT);
  assign fire0      = s0_v_r && (s0_contact || rdy1);
  assign rdy0       = !s0_v_r || s0_contact || rdy1;

  assign in_stall  = !rdy0;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // per-axis views of the input register
  logic signed [15:0] s0_dir [NumAxes];
  logic signed [31:0] s0_pos [NumAxes];

  always_comb begin
    s0_dir[0] = s0_r.dir_x;
    s0_dir[1] = s0_r.dir_y;
    s0_dir[2] = s0_r.dir_z;
    s0_pos[0] = s0_r.pos_x;
    s0_pos[1] = s0_r.pos_y;
    s0_pos[2] = s0_r.pos_z;
  end

  // contact multiply-accumulate and velocity difference
  logic signed [40:0] acc_prod  [NumAxes];
  logic signed [40:0] acc_shift [NumAxes];
  logic signed [40:0] acc_sum   [NumAxes];
  logic signed [31:0] sum_nxt   [NumAxes];
  logic signed [32:0] vel_diff  [NumAxes];
  logic [32:0]        dmag_nxt  [NumAxes];
  logic               dn_nxt    [NumAxes];
  logic               use_damp;

  assign use_damp = any_r && !first_r;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      acc_prod[a]  = 41'(s0_dir[a]) * 41'($signed({1'b0, s0_r.depth}));
      acc_shift[a] = acc_prod[a] >>> 14;
      acc_sum[a]   = $signed({{9{sum_r[a][31]}}, sum_r[a]}) + acc_shift[a];
      sum_nxt[a]   = sat32(acc_sum[a]);
      vel_diff[a]  = $signed({s0_pos[a][31], s0_pos[a]})
                   - $signed({prev_r[a][31], prev_r[a]});
      if (!use_damp) begin
        dmag_nxt[a] = '0;
      end else if (vel_diff[a][32]) begin
        dmag_nxt[a] = 33'(-vel_diff[a]);
      end else begin
        dmag_nxt[a] = 33'(vel_diff[a]);
      end
      dn_nxt[a] = use_damp && vel_diff[a][32];
    end
  end

  // stage 1 to 2 arithmetic
  logic signed [32:0] vis_wide [NumAxes];
  logic signed [31:0] vis_nxt  [NumAxes];
  logic [31:0]        offmag   [NumAxes];
  logic [63:0]        sm_nxt   [NumAxes];
  logic [64:0]        dp_nxt   [NumAxes];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      vis_wide[a] = $signed({s1_pos_r[a][31], s1_pos_r[a]})
                  + $signed({s1_off_r[a][31], s1_off_r[a]});
      vis_nxt[a]  = sat32($signed({{8{vis_wide[a][32]}}, vis_wide[a]}));
      offmag[a]   = s1_off_r[a][31] ? 32'(-s1_off_r[a]) : 32'(s1_off_r[a]);
      sm_nxt[a]   = 64'(stiff_r) * 64'(offmag[a]);
      dp_nxt[a]   = 65'(damp_r) * 65'(s1_dmag_r[a]);
    end
  end

  // stage 2 to 3: times ten with saturation
  logic [63:0] dm_nxt [NumAxes];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      if (s2_dp_r[a] > {1'b0, DampLimit}) begin
        dm_nxt[a] = '1;
      end else begin
        dm_nxt[a] = (s2_dp_r[a][63:0] << 3) + (s2_dp_r[a][63:0] << 1);
      end
    end
  end

  // stage 3 to 4: combine spring and damping terms
  logic [64:0] tot_sum [NumAxes];
  logic [63:0] mag_nxt [NumAxes];
  logic        neg_nxt [NumAxes];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      tot_sum[a] = {1'b0, s3_sm_r[a]} + {1'b0, s3_dm_r[a]};
      if (s3_sn_r[a] == s3_dn_r[a]) begin
        neg_nxt[a] = s3_sn_r[a];
        mag_nxt[a] = tot_sum[a][64] ? '1 : tot_sum[a][63:0];
      end else if (s3_sm_r[a] >= s3_dm_r[a]) begin
        neg_nxt[a] = s3_sn_r[a];
        mag_nxt[a] = s3_sm_r[a] - s3_dm_r[a];
      end else begin
        neg_nxt[a] = s3_dn_r[a];
        mag_nxt[a] = s3_dm_r[a] - s3_sm_r[a];
      end
    end
  end

  // stage 4 to output: floor shift and 48-bit saturation
  logic [48:0]        quo       [NumAxes];
  logic signed [47:0] force_nxt [NumAxes];
  out_item_t          out_nxt;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      quo[a] = {1'b0, s4_mag_r[a][63:16]}
             + 49'(s4_neg_r[a] && (s4_mag_r[a][15:0] != 16'd0));
      if (!s4_neg_r[a]) begin
        force_nxt[a] = (quo[a] > 49'(Force48Max)) ? Force48Max : quo[a][47:0];
      end else begin
        force_nxt[a] = (quo[a] > {2'b01, 47'd0}) ? Force48Min
                                                 : 48'(-quo[a][47:0]);
      end
    end
    out_nxt.force_valid = s4_fv_r;
    out_nxt.visual_x    = s4_vis_r[0];
    out_nxt.visual_y    = s4_vis_r[1];
    out_nxt.visual_z    = s4_vis_r[2];
    out_nxt.offset_x    = s4_off_r[0];
    out_nxt.offset_y    = s4_off_r[1];
    out_nxt.offset_z    = s4_off_r[2];
    out_nxt.force_x     = force_nxt[0];
    out_nxt.force_y     = force_nxt[1];
    out_nxt.force_z     = force_nxt[2];
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= '0;
      damp_r  <= '0;
      any_r   <= 1'b0;
      first_r <= 1'b1;
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        sum_r[a]  <= '0;
        prev_r[a] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_STIFFNESS: stiff_r <= cfg_wdata;
          REG_DAMPING:   damp_r  <= cfg_wdata;
          default:       ;
        endcase
      end
      if (rdy0) begin
        s0_v_r <= in_valid;
      end
      if (fire0) begin
        if (s0_contact) begin
          any_r <= 1'b1;
          for (int a = 0; a < NumAxes; a++) begin
            sum_r[a] <= sum_nxt[a];
          end
        end else begin
          any_r <= 1'b0;
          for (int a = 0; a < NumAxes; a++) begin
            sum_r[a] <= '0;
          end
          if (any_r) begin
            first_r <= 1'b0;
            for (int a = 0; a < NumAxes; a++) begin
              prev_r[a] <= s0_pos[a];
            end
          end
        end
      end
      if (rdy1) begin
        s1_v_r <= s0_v_r && !s0_contact;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (rdy_out) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s0_r <= in_item;
    end
    if (rdy1) begin
      s1_fv_r <= any_r;
      for (int a = 0; a < NumAxes; a++) begin
        s1_off_r[a]  <= sum_r[a];
        s1_pos_r[a]  <= s0_pos[a];
        s1_dmag_r[a] <= dmag_nxt[a];
        s1_dn_r[a]   <= dn_nxt[a];
      end
    end
    if (rdy2) begin
      s2_fv_r <= s1_fv_r;
      for (int a = 0; a < NumAxes; a++) begin
        s2_off_r[a] <= s1_off_r[a];
        s2_vis_r[a] <= vis_nxt[a];
        s2_sm_r[a]  <= sm_nxt[a];
        s2_sn_r[a]  <= s1_off_r[a][31];
        s2_dp_r[a]  <= dp_nxt[a];
        s2_dn_r[a]  <= s1_dn_r[a];
      end
    end
    if (rdy3) begin
      s3_fv_r <= s2_fv_r;
      for (int a = 0; a < NumAxes; a++) begin
        s3_off_r[a] <= s2_off_r[a];
        s3_vis_r[a] <= s2_vis_r[a];
        s3_sm_r[a]  <= s2_sm_r[a];
        s3_sn_r[a]  <= s2_sn_r[a];
        s3_dm_r[a]  <= dm_nxt[a];
        s3_dn_r[a]  <= s2_dn_r[a];
      end
    end
    if (rdy4) begin
      s4_fv_r <= s3_fv_r;
      for (int a = 0; a < NumAxes; a++) begin
        s4_off_r[a] <= s3_off_r[a];
        s4_vis_r[a] <= s3_vis_r[a];
        s4_mag_r[a] <= mag_nxt[a];
        s4_neg_r[a] <= neg_nxt[a];
      end
    end
    if (rdy_out) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  // an empty frame carries no offset and no force
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.force_valid) |->
      (out_r.offset_x == '0 && out_r.offset_y == '0 && out_r.offset_z == '0 &&
       out_r.force_x == '0 && out_r.force_y == '0 && out_r.force_z == '0))
    else $error("empty frame with nonzero offset or force");

  // sums stay clear until a contact arrives
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> (sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("sum nonzero without contacts");

  // first step flag only ever falls after reset
  a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
    !$rose(first_r))
    else $error("first step flag set again");

  // the input side only stalls on a held finish item
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_v_r && !s0_contact && s1_v_r))
    else $error("input stalled without a blocked finish item");
`endif

endmodule

`default_nettype wire
